/* hw/rtl/gn2d_pkg.sv */
// Shared types and constants for the 2D gradient noise block.
// No dependencies.
`default_nettype none
package gn2d_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned GradW  = 15;
  localparam int unsigned NoiseW = 16;

  typedef enum logic {
    OP_EVAL  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    logic                     is_write;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic [3:0]               entry_col;
    logic [3:0]               entry_row;
    logic signed [GradW-1:0]  grad_x;
    logic signed [GradW-1:0]  grad_y;
  } item_t;
endpackage
`default_nettype wire

/* hw/rtl/gn2d_front.sv */
// Front end: accepts input beats and queues them for the datapath.
// Depends on gn2d_pkg.
`default_nettype none
module gn2d_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  output logic                full_o,
  input  gn2d_pkg::item_t     item_i,
  output logic                valid_o,
  input  wire logic           take_i,
  output gn2d_pkg::item_t     item_o
);
  import gn2d_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wptr_q == rptr_q)
    else $error("queue pointers disagree with count");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |=> cnt_q <= 2'd1)
    else $error("queue count jumped");
endmodule
`default_nettype wire

/* hw/rtl/gn2d_back.sv */
// Back end: gradient table, corner dot products, blending, rounding.
// Depends on gn2d_pkg. Stages advance together when the output stage can move.
`default_nettype none
module gn2d_back #(
  parameter int unsigned GRID_W = 16,
  parameter int unsigned GRID_H = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                take_o,
  input  gn2d_pkg::item_t     item_i,
  output logic                empty_o,
  input  wire logic           pop_i,
  output logic signed [gn2d_pkg::NoiseW-1:0] noise_o
);
  import gn2d_pkg::*;

  localparam int unsigned Depth = GRID_W * GRID_H;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int unsigned RWd   = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int unsigned IW    = CoordW - 8 + 1;

  // Reciprocal constants for the index remainder: q = (mag * M) >> S is the
  // exact quotient for any IW-bit magnitude when S = IW + ceil(log2(N)).
  localparam int unsigned SX    = IW + $clog2(GRID_W);
  localparam int unsigned SY    = IW + $clog2(GRID_H);
  localparam logic [IW:0] MulX  =
    (IW+1)'(((64'd1 << SX) + 64'(GRID_W) - 64'd1) / 64'(GRID_W));
  localparam logic [IW:0] MulY  =
    (IW+1)'(((64'd1 << SY) + 64'(GRID_H) - 64'd1) / 64'(GRID_H));

  // Four read ports, so the table is held as four banked copies.
  logic [2*GradW-1:0] tab0 [Depth];
  logic [2*GradW-1:0] tab1 [Depth];
  logic [2*GradW-1:0] tab2 [Depth];
  logic [2*GradW-1:0] tab3 [Depth];

  // Pipeline: s1 index calc, s2 table read, s3 dots, s4 x blend, s5 y blend, s6 out.
  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  // ---- stage 0 -> 1: floor cell and remainder.
  logic signed [IW-1:0] x0, y0, x1, y1;
  logic                 wr_ok;
  assign x0 = IW'(item_i.coord_x >>> 8);
  assign y0 = IW'(item_i.coord_y >>> 8);
  assign x1 = x0 + IW'(1);
  assign y1 = y0 + IW'(1);

  function automatic logic [8:0] wrap_idx(logic signed [IW-1:0] i, logic [IW:0] m,
                                          int unsigned s, logic [8:0] n);
    logic [IW-1:0] mag;
    logic [2*IW:0] prod;
    logic [IW-1:0] q;
    logic [IW-1:0] r;
    mag  = i[IW-1] ? IW'(-i) : IW'(i);
    prod = (2*IW+1)'(mag) * (2*IW+1)'(m);
    q    = IW'(prod >> s);
    r    = mag - IW'(q * IW'(n));
    return 9'(r);
  endfunction

  assign wr_ok = (32'(item_i.entry_col) < GRID_W) && (32'(item_i.entry_row) < GRID_H);

  logic [CW-1:0]  c0_q, c1_q;
  logic [RWd-1:0] r0_q, r1_q;
  logic [7:0]     fx1_q, fy1_q;

  always_ff @(posedge clk_i) begin
    if (adv && valid_i && item_i.is_write == OP_WRITE && wr_ok) begin
      tab0[AW'(32'(item_i.entry_row) * GRID_W + 32'(item_i.entry_col))] <=
        {item_i.grad_x, item_i.grad_y};
      tab1[AW'(32'(item_i.entry_row) * GRID_W + 32'(item_i.entry_col))] <=
        {item_i.grad_x, item_i.grad_y};
      tab2[AW'(32'(item_i.entry_row) * GRID_W + 32'(item_i.entry_col))] <=
        {item_i.grad_x, item_i.grad_y};
      tab3[AW'(32'(item_i.entry_row) * GRID_W + 32'(item_i.entry_col))] <=
        {item_i.grad_x, item_i.grad_y};
    end
    if (adv) begin
      c0_q  <= CW'(wrap_idx(x0, MulX, SX, 9'(GRID_W)));
      c1_q  <= CW'(wrap_idx(x1, MulX, SX, 9'(GRID_W)));
      r0_q  <= RWd'(wrap_idx(y0, MulY, SY, 9'(GRID_H)));
      r1_q  <= RWd'(wrap_idx(y1, MulY, SY, 9'(GRID_H)));
      fx1_q <= item_i.coord_x[7:0];
      fy1_q <= item_i.coord_y[7:0];
    end
  end

  // ---- stage 2: registered table reads.
  logic [2*GradW-1:0] g00_q, g10_q, g01_q, g11_q;
  logic [7:0]         fx2_q, fy2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      g00_q <= tab0[AW'(32'(r0_q) * GRID_W + 32'(c0_q))];
      g10_q <= tab1[AW'(32'(r0_q) * GRID_W + 32'(c1_q))];
      g01_q <= tab2[AW'(32'(r1_q) * GRID_W + 32'(c0_q))];
      g11_q <= tab3[AW'(32'(r1_q) * GRID_W + 32'(c1_q))];
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
    end
  end

  // ---- stage 3: dot products (Q.22, 25 bits).
  function automatic logic signed [24:0] dot(logic [2*GradW-1:0] g,
                                            logic signed [9:0] dx, logic signed [9:0] dy);
    logic signed [GradW-1:0] gx, gy;
    gx = g[2*GradW-1:GradW];
    gy = g[GradW-1:0];
    return 25'(dx * gx) + 25'(dy * gy);
  endfunction

  logic signed [9:0] dx0, dx1, dy0, dy1;
  assign dx0 = {2'b00, fx2_q};
  assign dx1 = {2'b00, fx2_q} - 10'sd256;
  assign dy0 = {2'b00, fy2_q};
  assign dy1 = {2'b00, fy2_q} - 10'sd256;

  logic signed [24:0] n00_q, n10_q, n01_q, n11_q;
  logic [7:0]         fx3_q, fy3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n00_q <= dot(g00_q, dx0, dy0);
      n10_q <= dot(g10_q, dx1, dy0);
      n01_q <= dot(g01_q, dx0, dy1);
      n11_q <= dot(g11_q, dx1, dy1);
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
    end
  end

  // ---- stage 4: x blend (Q.30, 35 bits).
  logic signed [9:0]  wx0, wx1;
  logic signed [34:0] row0_q, row1_q;
  logic [7:0]         fy4_q;
  assign wx0 = 10'sd256 - {2'b00, fx3_q};
  assign wx1 = {2'b00, fx3_q};
  always_ff @(posedge clk_i) begin
    if (adv) begin
      row0_q <= 35'(wx0 * n00_q) + 35'(wx1 * n10_q);
      row1_q <= 35'(wx0 * n01_q) + 35'(wx1 * n11_q);
      fy4_q  <= fy3_q;
    end
  end

  // ---- stage 5: y blend (Q.38, 45 bits).
  logic signed [9:0]  wy0, wy1;
  logic signed [44:0] v_q;
  assign wy0 = 10'sd256 - {2'b00, fy4_q};
  assign wy1 = {2'b00, fy4_q};
  always_ff @(posedge clk_i) begin
    if (adv) v_q <= 45'(wy0 * row0_q) + 45'(wy1 * row1_q);
  end

  // ---- stage 6: round half up and saturate.
  logic signed [44:0] vr;
  logic signed [20:0] sh;
  logic signed [NoiseW-1:0] sat;
  assign vr = v_q + 45'sd8388608;
  assign sh = 21'(vr >>> 24);
  always_comb begin
    if (sh > 21'sd32767)       sat = 16'sh7fff;
    else if (sh < -21'sd32768) sat = 16'sh8000;
    else                       sat = NoiseW'(sh);
  end

  always_ff @(posedge clk_i) begin
    if (adv && v5_q) noise_o <= sat;
  end

  assign adv     = !v6_q || pop_i;
  assign take_o  = adv;
  assign empty_o = !v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i && (item_i.is_write == OP_EVAL);
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !pop_i) |=> (v6_q && $stable(noise_o)))
    else $error("waiting result changed");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v6_q && !pop_i) |-> !take_o)
    else $error("took a beat while stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v5_q) |=> v6_q)
    else $error("result lost at output stage");
endmodule
`default_nettype wire

/* hw/rtl/gradient_noise_2d.sv */
// Top level of the 2D gradient noise block: input queue plus datapath.
// Depends on gn2d_pkg, gn2d_front, gn2d_back.
//
//  channel | handshake    | payload
//  input   | push/full    | opcode_i coord_x_i coord_y_i entry_col_i entry_row_i grad_x_i grad_y_i
//  result  | pop/empty    | noise_value_o
//
// One beat per cycle sustained while results are popped; an evaluate result is
// registered in the input queue and then in each register of the six-register
// datapath pipeline before it appears at noise_value_o.
// Writes produce no result. Reset clears control state; table contents stay
// undefined until written. A stalled result stalls the whole datapath pipeline.
`default_nettype none
module gradient_noise_2d #(
  parameter int unsigned GRID_W = 16,
  parameter int unsigned GRID_H = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                opcode_i,
  input  wire logic signed [23:0]  coord_x_i,
  input  wire logic signed [23:0]  coord_y_i,
  input  wire logic [3:0]          entry_col_i,
  input  wire logic [3:0]          entry_row_i,
  input  wire logic signed [14:0]  grad_x_i,
  input  wire logic signed [14:0]  grad_y_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [15:0]       noise_value_o
);
  import gn2d_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_take;

  always_comb begin
    in_item.is_write  = opcode_i;
    in_item.coord_x   = coord_x_i;
    in_item.coord_y   = coord_y_i;
    in_item.entry_col = entry_col_i;
    in_item.entry_row = entry_row_i;
    in_item.grad_x    = grad_x_i;
    in_item.grad_y    = grad_y_i;
  end

  gn2d_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .valid_o(q_valid), .take_i(q_take), .item_o(q_item)
  );

  gn2d_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .take_o(q_take), .item_i(q_item),
    .empty_o(empty), .pop_i(pop), .noise_o(noise_value_o)
  );
endmodule
`default_nettype wire
